FILE: design/krrs_pkg.sv
// Package for the key rotation ring store: request and response payload types,
// request, status and register codes, and default sizes. No dependencies.
`default_nettype none

package krrs_pkg;

	// Default ring depth
	localparam int DEF_STORE_DEPTH = 128;

	// Configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 32;
	localparam logic [CFG_IDX_W-1:0] CFG_STORE_ENABLED   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ROTATE_INTERVAL = 1'd1;
	localparam logic [31:0] ROTATE_INTERVAL_RESET = 32'd1800;

	// Request codes
	localparam logic [1:0] REQ_ROTATE = 2'd0;
	localparam logic [1:0] REQ_FIND   = 2'd1;
	localparam logic [1:0] REQ_NEWEST = 2'd2;
	localparam logic [1:0] REQ_CLEAR  = 2'd3;

	// Status codes
	localparam logic [1:0] STAT_DONE         = 2'd0;
	localparam logic [1:0] STAT_NOT_ENABLED  = 2'd1;
	localparam logic [1:0] STAT_TOO_SOON     = 2'd2;
	localparam logic [1:0] STAT_NOT_FOUND    = 2'd3;

	typedef struct packed {
		logic [1:0]  req_type;
		logic        force_req;
		logic [31:0] now_s;
		logic [63:0] key_tag;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic        found;
		logic [6:0]  age;
		logic [6:0]  slot;
		logic [63:0] key_out;
		logic [7:0]  entries;
	} rsp_t;

endpackage

`default_nettype wire

FILE: design/krrs_if.sv
// Valid/ready channel interfaces for requests and responses of the ring store.
// Depends on krrs_pkg for the payload types.
`default_nettype none

interface krrs_req_if import krrs_pkg::*; ();
	logic valid;
	logic ready;
	req_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface krrs_rsp_if import krrs_pkg::*; ();
	logic valid;
	logic ready;
	rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: design/krrs_step.sv
// Shared step unit of the ring walk: wrapped slot increment and decrement,
// key tag compare and end-of-walk detect. Depends on nothing but its parameter.
`default_nettype none

module krrs_step #(
	parameter int STORE_DEPTH = 128,
	localparam int SW = $clog2(STORE_DEPTH),
	localparam int CW = $clog2(STORE_DEPTH + 1)
) (
	input  wire logic [SW-1:0] cur_slot,
	input  wire logic [SW-1:0] head,
	input  wire logic [SW-1:0] age,
	input  wire logic [CW-1:0] count,
	input  wire logic [63:0]   rd_key,
	input  wire logic [63:0]   ref_key,
	output      logic [SW-1:0] next_slot,
	output      logic [SW-1:0] prev_head,
	output      logic          hit,
	output      logic          last
);

	localparam logic [SW-1:0] LAST_SLOT = SW'(STORE_DEPTH - 1);

	logic [CW:0] age_inc;

	// Advance one slot toward the oldest entry, wrapping at the depth
	assign next_slot = (cur_slot == LAST_SLOT) ? '0 : cur_slot + 1'b1;

	// Step the head one slot back, wrapping at zero
	assign prev_head = (head == '0) ? LAST_SLOT : head - 1'b1;

	// Compare the tag read from the ring against the searched tag
	assign hit = (rd_key == ref_key);

	// Flag the oldest valid entry
	assign age_inc = (CW + 1)'(age) + 1'b1;
	assign last    = (age_inc == (CW + 1)'(count));

endmodule

`default_nettype wire

FILE: design/key_rotation_ring_store.sv
// Key rotation ring store. Rotate, clear and refused requests, and a find or read newest
// on an empty store, pass through the done state to the output register; read newest
// first passes a head-read state; a find walks newest first, one ring entry per cycle
// through the single registered read port, to a match or the oldest entry. One request
// is in work at a time; the next is taken the cycle after the response loads. Reset
// clears head, count, rotate time and the registers; ring contents stay undefined.
`default_nettype none

module key_rotation_ring_store import krrs_pkg::*; #(
	parameter int STORE_DEPTH = DEF_STORE_DEPTH
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	krrs_req_if.sink                   req,
	krrs_rsp_if.source                 rsp,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int SW = $clog2(STORE_DEPTH);
	localparam int CW = $clog2(STORE_DEPTH + 1);
	localparam logic [CW-1:0] FULL_COUNT = CW'(STORE_DEPTH);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_NEWEST = 2'd1;
	localparam logic [1:0] ST_WALK   = 2'd2;
	localparam logic [1:0] ST_DONE   = 2'd3;

	logic [1:0]    state_q;
	logic          enabled_q;
	logic [31:0]   interval_q;
	logic [SW-1:0] head_q;
	logic [CW-1:0] count_q;
	logic [31:0]   last_time_q;
	logic [SW-1:0] cmp_idx_q;
	logic [SW-1:0] age_q;
	logic [63:0]   ref_key_q;
	rsp_t          res_q;
	rsp_t          res_d;
	rsp_t          done_rsp;
	rsp_t          rsp_data_q;
	logic          rsp_valid_q;

	logic [63:0]   ring_q [STORE_DEPTH];
	logic [63:0]   rd_data_q;
	logic [SW-1:0] rd_addr;

	logic [SW-1:0] next_slot;
	logic [SW-1:0] prev_head;
	logic          hit;
	logic          last;

	logic          req_fire;
	logic          out_free;
	logic          elapsed;
	logic [31:0]   delta;
	logic [SW-1:0] new_head;
	logic [SW+6:0] slot_ext_head;
	logic [SW+6:0] slot_ext_new;
	logic [SW+6:0] slot_ext_cmp;
	logic [SW+6:0] age_ext;
	logic [CW+7:0] count_ext;

	krrs_step #(
		.STORE_DEPTH(STORE_DEPTH)
	) u_step (
		.cur_slot (cmp_idx_q),
		.head     (head_q),
		.age      (age_q),
		.count    (count_q),
		.rd_key   (rd_data_q),
		.ref_key  (ref_key_q),
		.next_slot(next_slot),
		.prev_head(prev_head),
		.hit      (hit),
		.last     (last)
	);

	assign req.ready = (state_q == ST_IDLE);
	assign req_fire  = req.valid && req.ready;
	assign out_free  = !rsp_valid_q || rsp.ready;

	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_data_q;

	// Interval check for unforced rotations
	assign delta   = req.data.now_s - last_time_q;
	assign elapsed = (req.data.now_s >= last_time_q) && (delta >= interval_q);

	// First insert lands in slot zero, later ones one slot before the head
	assign new_head = (count_q == '0) ? '0 : prev_head;

	// Narrow internal indexes to the response field widths
	assign slot_ext_head = {7'd0, head_q};
	assign slot_ext_new  = {7'd0, new_head};
	assign slot_ext_cmp  = {7'd0, cmp_idx_q};
	assign age_ext       = {7'd0, age_q};
	assign count_ext     = {8'd0, count_q};

	// Read the head at accept, the next walk slot while walking
	assign rd_addr = (state_q == ST_WALK) ? next_slot : head_q;

	// Ring memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (req_fire && enabled_q && (req.data.req_type == REQ_ROTATE) &&
				(req.data.force_req || (count_q == '0) || elapsed)) begin
			ring_q[new_head] <= req.data.key_tag;
		end
		rd_data_q <= ring_q[rd_addr];
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q  <= 1'b0;
			interval_q <= ROTATE_INTERVAL_RESET;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_STORE_ENABLED:   enabled_q  <= cfg_data[0];
				CFG_ROTATE_INTERVAL: interval_q <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	// Sequencer and ring pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			head_q      <= '0;
			count_q     <= '0;
			last_time_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (req_fire) begin
						if (req.data.req_type == REQ_CLEAR) begin
							head_q      <= '0;
							count_q     <= '0;
							last_time_q <= '0;
							state_q     <= ST_DONE;
						end else if (!enabled_q) begin
							state_q <= ST_DONE;
						end else begin
							case (req.data.req_type)
								REQ_ROTATE: begin
									if (req.data.force_req || (count_q == '0) || elapsed) begin
										head_q      <= new_head;
										last_time_q <= req.data.now_s;
										if (count_q != FULL_COUNT) begin
											count_q <= count_q + 1'b1;
										end
									end
									state_q <= ST_DONE;
								end
								REQ_FIND: begin
									state_q <= (count_q == '0) ? ST_DONE : ST_WALK;
								end
								default: begin
									state_q <= (count_q == '0) ? ST_DONE : ST_NEWEST;
								end
							endcase
						end
					end
				end
				ST_NEWEST: begin
					state_q <= ST_DONE;
				end
				ST_WALK: begin
					if (hit || last) begin
						state_q <= ST_DONE;
					end
				end
				default: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
			endcase
		end
	end

	// Build the pending result for the current state
	always_comb begin
		res_d = res_q;
		case (state_q)
			ST_IDLE: begin
				res_d = '0;
				if (req_fire) begin
					if (req.data.req_type == REQ_CLEAR) begin
						res_d.status = STAT_DONE;
					end else if (!enabled_q) begin
						res_d.status = STAT_NOT_ENABLED;
					end else begin
						case (req.data.req_type)
							REQ_ROTATE: begin
								if (req.data.force_req || (count_q == '0) || elapsed) begin
									res_d.status = STAT_DONE;
									res_d.slot   = slot_ext_new[6:0];
								end else begin
									res_d.status = STAT_TOO_SOON;
								end
							end
							default: begin
								res_d.status = STAT_NOT_FOUND;
							end
						endcase
					end
				end
			end
			ST_NEWEST: begin
				res_d.status  = STAT_DONE;
				res_d.found   = 1'b1;
				res_d.slot    = slot_ext_head[6:0];
				res_d.key_out = rd_data_q;
			end
			ST_WALK: begin
				if (hit) begin
					res_d.status = STAT_DONE;
					res_d.found  = 1'b1;
					res_d.age    = age_ext[6:0];
					res_d.slot   = slot_ext_cmp[6:0];
				end
			end
			default: ;
		endcase
	end

	// Walk position, searched tag and pending result
	always_ff @(posedge clk) begin
		res_q <= res_d;
		case (state_q)
			ST_IDLE: begin
				cmp_idx_q <= head_q;
				age_q     <= '0;
				ref_key_q <= req.data.key_tag;
			end
			ST_WALK: begin
				if (!hit) begin
					cmp_idx_q <= next_slot;
					age_q     <= age_q + 1'b1;
				end
			end
			default: ;
		endcase
	end

	// Attach the entry count to the finished result
	always_comb begin
		done_rsp         = res_q;
		done_rsp.entries = count_ext[7:0];
	end

	// Output register: hold until the transfer completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			rsp_data_q <= done_rsp;
		end
	end

endmodule

`default_nettype wire

FILE: tb/krrs_outcome_checker.sv
// Outcome checker for the key rotation ring store: watches the request, response
// and register-write ports, predicts each response and compares it field by field.
// Depends on krrs_pkg for payload types, codes and the default ring depth.
`default_nettype none

module krrs_outcome_checker import krrs_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  req_valid,
	input  wire logic                  req_ready,
	input  wire req_t                  req_data,
	input  wire logic                  rsp_valid,
	input  wire logic                  rsp_ready,
	input  wire rsp_t                  rsp_data,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output int                         mismatches,
	output int                         backlog
);

	localparam int DEPTH = DEF_STORE_DEPTH;

	// Shadow copy of the ring and its registers
	logic [63:0] tag_ring [DEPTH];
	int unsigned newest_slot;
	int unsigned fill_level;
	logic [31:0] rotated_at;
	logic        ring_on;
	logic [31:0] min_gap_s;

	// Responses predicted but not yet seen, oldest first
	rsp_t outcomes_due [$];

	// Apply one request to the shadow ring and return the response it earns
	function automatic rsp_t ring_outcome(input req_t r);
		rsp_t        o;
		logic [31:0] elapsed;
		int unsigned idx;
		bit          hit;
		o = '0;
		elapsed = r.now_s - rotated_at;
		hit = 1'b0;
		if (r.req_type == REQ_CLEAR) begin
			newest_slot = 0;
			fill_level  = 0;
			rotated_at  = '0;
			o.status    = STAT_DONE;
		end else if (!ring_on) begin
			o.status = STAT_NOT_ENABLED;
		end else if (r.req_type == REQ_ROTATE) begin
			// Skip an unforced rotate that comes too early or with the clock behind
			if (!r.force_req && fill_level > 0 &&
					!(r.now_s >= rotated_at && elapsed >= min_gap_s)) begin
				o.status = STAT_TOO_SOON;
			end else begin
				newest_slot = (fill_level == 0) ? 0 : (newest_slot + DEPTH - 1) % DEPTH;
				tag_ring[newest_slot] = r.key_tag;
				if (fill_level < DEPTH)
					fill_level++;
				rotated_at = r.now_s;
				o.status   = STAT_DONE;
				o.slot     = newest_slot[6:0];
			end
		end else if (r.req_type == REQ_FIND) begin
			// Walk from newest to oldest, stop at the first match
			o.status = STAT_NOT_FOUND;
			for (int unsigned i = 0; i < fill_level; i++) begin
				idx = (newest_slot + i) % DEPTH;
				if (!hit && tag_ring[idx] == r.key_tag) begin
					hit      = 1'b1;
					o.status = STAT_DONE;
					o.found  = 1'b1;
					o.age    = i[6:0];
					o.slot   = idx[6:0];
				end
			end
		end else if (fill_level == 0) begin
			o.status = STAT_NOT_FOUND;
		end else begin
			o.status  = STAT_DONE;
			o.found   = 1'b1;
			o.slot    = newest_slot[6:0];
			o.key_out = tag_ring[newest_slot];
		end
		o.entries = fill_level[7:0];
		return o;
	endfunction

	// Track register writes, predict on request transfers, compare on response transfers
	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			newest_slot = 0;
			fill_level  = 0;
			rotated_at  = '0;
			ring_on     = 1'b0;
			min_gap_s   = ROTATE_INTERVAL_RESET;
			outcomes_due.delete();
			mismatches  = 0;
			backlog    <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					CFG_STORE_ENABLED:   ring_on   = cfg_data[0];
					CFG_ROTATE_INTERVAL: min_gap_s = cfg_data;
					default: ;
				endcase
			end
			if (rsp_valid && rsp_ready) begin
				if (outcomes_due.size() == 0) begin
					$error("response transfer with no request outstanding");
					mismatches++;
				end else begin
					want = outcomes_due.pop_front();
					if (rsp_data.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, rsp_data.status);
						mismatches++;
					end
					if (rsp_data.found !== want.found) begin
						$error("found: expected %0d, got %0d", want.found, rsp_data.found);
						mismatches++;
					end
					if (rsp_data.age !== want.age) begin
						$error("age: expected %0d, got %0d", want.age, rsp_data.age);
						mismatches++;
					end
					if (rsp_data.slot !== want.slot) begin
						$error("slot: expected %0d, got %0d", want.slot, rsp_data.slot);
						mismatches++;
					end
					if (rsp_data.key_out !== want.key_out) begin
						$error("key_out: expected %h, got %h", want.key_out, rsp_data.key_out);
						mismatches++;
					end
					if (rsp_data.entries !== want.entries) begin
						$error("entries: expected %0d, got %0d", want.entries, rsp_data.entries);
						mismatches++;
					end
				end
			end
			if (req_valid && req_ready)
				outcomes_due.insert(outcomes_due.size(), ring_outcome(req_data));
			backlog <= outcomes_due.size();
		end
	end

endmodule

`default_nettype wire

FILE: tb/tb_key_rotation_ring_store.sv
// Testbench top for the key rotation ring store: clock, reset, register writes,
// request stimulus with bursts and gaps, response stalls and the final verdict.
// Depends on krrs_pkg, krrs_if and krrs_outcome_checker.
`default_nettype none

module tb_key_rotation_ring_store;
	import krrs_pkg::*;

	localparam int CYCLE_LIMIT = 1_200_000;
	localparam int HOLD_OFF    = 300;
	localparam int DRAIN       = 8;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_data;
	int                    mismatches;
	int                    backlog;
	int                    cycle_count;

	// Stimulus bookkeeping
	int          burst_left;
	logic [31:0] clock_s;
	logic [31:0] interval_now;
	logic [63:0] recent_tags [$];
	bit          hold_off_due;

	krrs_req_if req_ch ();
	krrs_rsp_if rsp_ch ();

	key_rotation_ring_store DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req_ch),
		.rsp      (rsp_ch),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data)
	);

	krrs_outcome_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_ch.valid),
		.req_ready  (req_ch.ready),
		.req_data   (req_ch.data),
		.rsp_valid  (rsp_ch.valid),
		.rsp_ready  (rsp_ch.ready),
		.rsp_data   (rsp_ch.data),
		.cfg_we     (cfg_we),
		.cfg_idx    (cfg_idx),
		.cfg_data   (cfg_data),
		.mismatches (mismatches),
		.backlog    (backlog)
	);

	// Free-running clock
	initial clk = 1'b0;
	always #1 clk = ~clk;

	// Abort a run that hangs
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("** key_rotation_ring_store: FAILED **");
		$finish;
	end

	// Stall responses on a changing pattern, with one long hold-off under load
	initial begin
		int mode;
		int span;
		rsp_ch.ready = 1'b0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			if (hold_off_due) begin
				hold_off_due = 1'b0;
				rsp_ch.ready <= 1'b0;
				repeat (HOLD_OFF) @(posedge clk);
			end
			mode = $urandom_range(0, 3);
			span = $urandom_range(8, 64);
			repeat (span) begin
				case (mode)
					0: rsp_ch.ready <= 1'b1;
					1: rsp_ch.ready <= 1'($urandom_range(0, 1));
					2: rsp_ch.ready <= ($urandom_range(0, 7) == 0);
					default: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
				endcase
				@(posedge clk);
			end
		end
	end

	function automatic req_t pack_req(input logic [1:0] kind, input logic force_it,
			input logic [31:0] now, input logic [63:0] tag);
		req_t r;
		r.req_type  = kind;
		r.force_req = force_it;
		r.now_s     = now;
		r.key_tag   = tag;
		return r;
	endfunction

	// Draw a random request; rotates follow a wandering clock, finds mostly hit known tags
	function automatic req_t draw_request(input bit fill_heavy);
		req_t        r;
		int unsigned pick;
		r.force_req = 1'($urandom_range(0, 1));
		r.now_s     = $urandom();
		r.key_tag   = {$urandom(), $urandom()};
		pick = $urandom_range(0, 99);
		if (fill_heavy)
			r.req_type = (pick < 75) ? REQ_ROTATE : (pick < 95) ? REQ_FIND : REQ_NEWEST;
		else
			r.req_type = (pick < 40) ? REQ_ROTATE : (pick < 75) ? REQ_FIND :
				(pick < 97) ? REQ_NEWEST : REQ_CLEAR;
		case (r.req_type)
			REQ_ROTATE: begin
				pick = $urandom_range(0, 99);
				if (pick < 55)
					clock_s += $urandom_range(0, 40);
				else if (pick < 75)
					clock_s += interval_now - $urandom_range(0, 1);
				else if (pick < 85)
					clock_s -= $urandom_range(1, 50);
				else if (pick < 95)
					clock_s = $urandom();
				r.now_s = clock_s;
				pick = $urandom_range(0, 99);
				if (pick < 8 && recent_tags.size() > 0)
					r.key_tag = recent_tags[$urandom_range(0, recent_tags.size() - 1)];
				else if (pick < 10)
					r.key_tag = '0;
				else if (pick < 12)
					r.key_tag = '1;
				recent_tags.insert(recent_tags.size(), r.key_tag);
				if (recent_tags.size() > 200)
					void'(recent_tags.pop_front());
			end
			REQ_FIND: begin
				if ($urandom_range(0, 3) != 0 && recent_tags.size() > 0)
					r.key_tag = recent_tags[$urandom_range(0, recent_tags.size() - 1)];
			end
			default: ;
		endcase
		return r;
	endfunction

	// Offer one request in bursts with random gaps; return at its transfer edge
	task automatic offer(input req_t item);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				req_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		req_ch.valid <= 1'b1;
		req_ch.data  <= item;
		do @(posedge clk); while (!req_ch.ready);
	endtask

	// Write a register once every outstanding response has come back
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
		req_ch.valid <= 1'b0;
		burst_left = 0;
		do @(posedge clk); while (backlog != 0);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we   <= 1'b0;
		if (idx == CFG_ROTATE_INTERVAL)
			interval_now = value;
	endtask

	// Stimulus: directed corners, then randomized phases under several settings
	initial begin
		int          phase_items [9];
		logic [31:0] phase_gap_s [9];
		arst_n       = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.data  = '0;
		cfg_we       = 1'b0;
		cfg_idx      = '0;
		cfg_data     = '0;
		burst_left   = 0;
		clock_s      = '0;
		interval_now = ROTATE_INTERVAL_RESET;
		hold_off_due = 1'b0;
		phase_items  = '{400, 160, 160, 160, 60, 160, 160, 160, 160};
		phase_gap_s  = '{32'd0, ROTATE_INTERVAL_RESET, $urandom_range(1, 30), 32'hFFFF_FFFF,
			32'd5, $urandom(), 32'd0, $urandom_range(1, 30), $urandom_range(31, 300)};
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Disabled after reset; clear still works
		offer(pack_req(REQ_ROTATE, 1'b1, 32'd10, 64'h1111_2222_3333_4444));
		offer(pack_req(REQ_FIND, 1'b0, 32'd0, 64'h1111_2222_3333_4444));
		offer(pack_req(REQ_NEWEST, 1'b0, 32'd0, '0));
		offer(pack_req(REQ_CLEAR, 1'b0, 32'd0, '0));
		write_reg(CFG_STORE_ENABLED, 32'd1);

		// Empty store, first insert, too-early, clock behind, forced rotate
		offer(pack_req(REQ_NEWEST, 1'b0, 32'd0, '0));
		offer(pack_req(REQ_FIND, 1'b0, 32'd0, '1));
		offer(pack_req(REQ_ROTATE, 1'b0, 32'd100, '1));
		offer(pack_req(REQ_ROTATE, 1'b0, 32'd200, 64'h0123_4567_89AB_CDEF));
		offer(pack_req(REQ_ROTATE, 1'b0, 32'd1900, '0));
		offer(pack_req(REQ_ROTATE, 1'b0, 32'd5, 64'hDEAD_BEEF_0000_0001));
		offer(pack_req(REQ_ROTATE, 1'b1, 32'd5, 64'hA5A5_A5A5_5A5A_5A5A));
		offer(pack_req(REQ_FIND, 1'b1, '1, '1));
		offer(pack_req(REQ_FIND, 1'b0, 32'd0, '0));
		offer(pack_req(REQ_FIND, 1'b0, 32'd0, {$urandom(), $urandom()}));
		offer(pack_req(REQ_NEWEST, 1'b1, '1, '1));
		offer(pack_req(REQ_CLEAR, 1'b1, '1, '1));
		offer(pack_req(REQ_ROTATE, 1'b0, 32'd0, 64'h8000_0000_0000_0001));

		// Widest interval: only the full span counts as elapsed
		write_reg(CFG_ROTATE_INTERVAL, 32'hFFFF_FFFF);
		offer(pack_req(REQ_ROTATE, 1'b0, 32'hFFFF_FFFE, 64'h0F0F_0F0F_0F0F_0F0F));
		offer(pack_req(REQ_ROTATE, 1'b0, 32'hFFFF_FFFF, 64'hF0F0_F0F0_F0F0_F0F0));

		// Zero interval: equal time passes, earlier time does not
		write_reg(CFG_ROTATE_INTERVAL, 32'd0);
		offer(pack_req(REQ_ROTATE, 1'b0, 32'd0, 64'h0000_0000_FFFF_FFFF));
		offer(pack_req(REQ_ROTATE, 1'b0, 32'hFFFF_FFFF, 64'hFFFF_FFFF_0000_0000));

		// Disable keeps contents; re-enable sees them again
		write_reg(CFG_STORE_ENABLED, 32'd0);
		offer(pack_req(REQ_FIND, 1'b0, 32'd0, '1));
		offer(pack_req(REQ_NEWEST, 1'b0, 32'd0, '0));
		offer(pack_req(REQ_ROTATE, 1'b1, 32'd0, '1));
		write_reg(CFG_STORE_ENABLED, 32'd1);
		offer(pack_req(REQ_NEWEST, 1'b0, 32'd0, '0));
		offer(pack_req(REQ_CLEAR, 1'b0, 32'd0, '0));

		// Random phases; the first fills and wraps the ring under a long response stall
		clock_s = '0;
		hold_off_due = 1'b1;
		for (int p = 0; p < 9; p++) begin
			write_reg(CFG_STORE_ENABLED, (p == 4) ? 32'd0 : 32'd1);
			write_reg(CFG_ROTATE_INTERVAL, phase_gap_s[p]);
			for (int n = 0; n < phase_items[p]; n++)
				offer(draw_request(p == 0));
		end

		// Drain and give the verdict
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (backlog != 0);
		repeat (DRAIN) @(posedge clk);
		if (mismatches == 0 && backlog == 0)
			$display("** key_rotation_ring_store: PASSED **");
		else
			$display("** key_rotation_ring_store: FAILED **");
		$finish;
	end

endmodule

`default_nettype wire
